### rtl/sqpd_pkg.sv
// ----------------------------------------------------------------------------
// sqpd_pkg
// Shared types and codes for the SOGI quadrature phase detector: register
// indexes, product term codes, sequencer states and control groups.
// ----------------------------------------------------------------------------
package sqpd_pkg;

  // Width of one multiplier digit taken from the serial operand per cycle
  localparam int DIGIT_W = 4;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BP_GAIN   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FB_FIRST  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FB_SECOND = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LP_GAIN   = 2'd3;

  // Product terms, in the order the sequencer issues them
  localparam int TERM_W = 3;
  localparam logic [TERM_W-1:0] TERM_BP_NUM = 3'd0;  // b0 * (u0 - u2)
  localparam logic [TERM_W-1:0] TERM_BP_FB1 = 3'd1;  // a1 * alpha1
  localparam logic [TERM_W-1:0] TERM_BP_FB2 = 3'd2;  // a2 * alpha2
  localparam logic [TERM_W-1:0] TERM_LP_NUM = 3'd3;  // qb0 * (u0 + 2u1 + u2)
  localparam logic [TERM_W-1:0] TERM_LP_FB1 = 3'd4;  // a1 * beta1
  localparam logic [TERM_W-1:0] TERM_LP_FB2 = 3'd5;  // a2 * beta2
  localparam logic [TERM_W-1:0] TERM_Q_COS  = 3'd6;  // cos * alpha
  localparam logic [TERM_W-1:0] TERM_Q_SIN  = 3'd7;  // sin * beta

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_ROUND,
    ST_CAPTURE
  } state_t;

  typedef struct packed {
    logic start;
    logic clear_acc;
  } mac_ctrl_t;

  typedef struct packed {
    logic load;
    logic coef_frac;
  } round_ctrl_t;

endpackage

### rtl/sogi_qsg_phase_detector.sv
// ----------------------------------------------------------------------------
// sogi_qsg_phase_detector
// SOGI quadrature signal generator with Park q-axis phase error output.
//
//   Channel   Dir  Handshake               Payload (lowest bits first)
//   s_axis    in   tvalid / tready         sample, osc_cos, osc_sin
//   m_axis    out  tvalid / tready         q_error, alpha_out, beta_out
//   cfg       in   cfg_we                  cfg_index, cfg_data (Q3.20)
//
// Each product takes NDIG = ceil((SAMPLE_WIDTH+2)/4) operand digits, 5 at SW 16.
// Eight products run one after another through the shared 4-bit serial MAC.
// A new request is taken once the previous result sits in the output
// register; a stalled result blocks only the next result write-back.
// Reset is synchronous and clears coefficients, histories and control state.
// ----------------------------------------------------------------------------
module sogi_qsg_phase_detector #(
  parameter int  SAMPLE_WIDTH = 16,
  parameter int  COEF_WIDTH   = 24,
  localparam int TDATA_W      = ((3 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sqpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [COEF_WIDTH-1:0]            cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [TDATA_W-1:0]               s_axis_tdata,  // sample, osc_cos, osc_sin
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [TDATA_W-1:0]               m_axis_tdata   // q_error, alpha_out, beta_out
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int MW  = (COEF_WIDTH > SAMPLE_WIDTH) ? COEF_WIDTH : SAMPLE_WIDTH;
  localparam int OPW = ((SAMPLE_WIDTH + 2 + sqpd_pkg::DIGIT_W - 1) / sqpd_pkg::DIGIT_W)
                       * sqpd_pkg::DIGIT_W;
  localparam int ACC_W       = MW + OPW + 2;
  localparam int COEF_FRAC   = COEF_WIDTH - 4;
  localparam int SAMPLE_FRAC = SAMPLE_WIDTH - 1;

  sqpd_pkg::state_t       state;
  sqpd_pkg::state_t       state_next;
  logic [sqpd_pkg::TERM_W-1:0] term;

  logic signed [COEF_WIDTH-1:0] reg_b0;
  logic signed [COEF_WIDTH-1:0] reg_a1;
  logic signed [COEF_WIDTH-1:0] reg_a2;
  logic signed [COEF_WIDTH-1:0] reg_qb0;

  logic signed [SW-1:0] u0;
  logic signed [SW-1:0] osc_c;
  logic signed [SW-1:0] osc_s;
  logic signed [SW-1:0] u1;
  logic signed [SW-1:0] u2;
  logic signed [SW-1:0] alpha1;
  logic signed [SW-1:0] alpha2;
  logic signed [SW-1:0] beta1;
  logic signed [SW-1:0] beta2;
  logic signed [SW-1:0] alpha_cur;
  logic signed [SW-1:0] beta_cur;
  logic        [SW-1:0] out_q;
  logic        [SW-1:0] out_alpha;
  logic        [SW-1:0] out_beta;
  logic                 m_valid;

  logic signed [SW:0]     bp_num;
  logic signed [SW+1:0]   lp_num;
  logic signed [MW-1:0]   mcand_sel;
  logic signed [OPW-1:0]  opnd_sel;

  sqpd_pkg::mac_ctrl_t    mac_ctrl;
  sqpd_pkg::round_ctrl_t  round_ctrl;
  logic                   mac_done;
  logic signed [ACC_W-1:0] acc;
  logic signed [SW-1:0]   round_result;

  logic accept;
  logic term_inc;
  logic out_load;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_b0  <= '0;
      reg_a1  <= '0;
      reg_a2  <= '0;
      reg_qb0 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sqpd_pkg::CFG_BP_GAIN:   reg_b0  <= $signed(cfg_data);
        sqpd_pkg::CFG_FB_FIRST:  reg_a1  <= $signed(cfg_data);
        sqpd_pkg::CFG_FB_SECOND: reg_a2  <= $signed(cfg_data);
        sqpd_pkg::CFG_LP_GAIN:   reg_qb0 <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Numerator taps of the two biquads
  assign bp_num = (SW + 1)'(u0) - (SW + 1)'(u2);
  assign lp_num = (SW + 2)'(u0) + ((SW + 2)'(u1) <<< 1) + (SW + 2)'(u2);

  always_comb begin
    case (term)
      sqpd_pkg::TERM_BP_NUM: begin
        mcand_sel = MW'(reg_b0);
        opnd_sel  = OPW'(bp_num);
      end
      sqpd_pkg::TERM_BP_FB1: begin
        mcand_sel = MW'(reg_a1);
        opnd_sel  = OPW'(alpha1);
      end
      sqpd_pkg::TERM_BP_FB2: begin
        mcand_sel = MW'(reg_a2);
        opnd_sel  = OPW'(alpha2);
      end
      sqpd_pkg::TERM_LP_NUM: begin
        mcand_sel = MW'(reg_qb0);
        opnd_sel  = OPW'(lp_num);
      end
      sqpd_pkg::TERM_LP_FB1: begin
        mcand_sel = MW'(reg_a1);
        opnd_sel  = OPW'(beta1);
      end
      sqpd_pkg::TERM_LP_FB2: begin
        mcand_sel = MW'(reg_a2);
        opnd_sel  = OPW'(beta2);
      end
      sqpd_pkg::TERM_Q_COS: begin
        mcand_sel = MW'(osc_c);
        opnd_sel  = OPW'(alpha_cur);
      end
      sqpd_pkg::TERM_Q_SIN: begin
        mcand_sel = MW'(osc_s);
        opnd_sel  = OPW'(beta_cur);
      end
      default: begin
        mcand_sel = '0;
        opnd_sel  = '0;
      end
    endcase
  end

  sqpd_serial_mac #(
    .MW    (MW),
    .OPW   (OPW),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mac_ctrl),
    .mcand_in (mcand_sel),
    .opnd_in  (opnd_sel),
    .done     (mac_done),
    .acc      (acc)
  );

  sqpd_round_sat #(
    .ACC_W       (ACC_W),
    .SW          (SW),
    .COEF_FRAC   (COEF_FRAC),
    .SAMPLE_FRAC (SAMPLE_FRAC)
  ) u_round (
    .clk    (clk),
    .ctrl   (round_ctrl),
    .acc    (acc),
    .result (round_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sqpd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next           = state;
    s_axis_tready        = 1'b0;
    accept               = 1'b0;
    term_inc             = 1'b0;
    out_load             = 1'b0;
    mac_ctrl.start       = 1'b0;
    mac_ctrl.clear_acc   = (term == sqpd_pkg::TERM_BP_NUM) ||
                           (term == sqpd_pkg::TERM_LP_NUM) ||
                           (term == sqpd_pkg::TERM_Q_COS);
    round_ctrl.load      = 1'b0;
    round_ctrl.coef_frac = (term != sqpd_pkg::TERM_Q_SIN);
    case (state)
      sqpd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          accept     = 1'b1;
          state_next = sqpd_pkg::ST_ISSUE;
        end
      end
      sqpd_pkg::ST_ISSUE: begin
        mac_ctrl.start = 1'b1;
        state_next     = sqpd_pkg::ST_WAIT;
      end
      sqpd_pkg::ST_WAIT: begin
        if (mac_done) begin
          if ((term == sqpd_pkg::TERM_BP_FB2) || (term == sqpd_pkg::TERM_LP_FB2) ||
              (term == sqpd_pkg::TERM_Q_SIN)) begin
            state_next = sqpd_pkg::ST_ROUND;
          end else begin
            term_inc   = 1'b1;
            state_next = sqpd_pkg::ST_ISSUE;
          end
        end
      end
      sqpd_pkg::ST_ROUND: begin
        round_ctrl.load = 1'b1;
        state_next      = sqpd_pkg::ST_CAPTURE;
      end
      sqpd_pkg::ST_CAPTURE: begin
        if (term == sqpd_pkg::TERM_Q_SIN) begin
          // Hold until the output register is free
          if (!m_valid || m_axis_tready) begin
            out_load   = 1'b1;
            state_next = sqpd_pkg::ST_IDLE;
          end
        end else begin
          term_inc   = 1'b1;
          state_next = sqpd_pkg::ST_ISSUE;
        end
      end
      default: begin
        state_next = sqpd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term    <= sqpd_pkg::TERM_BP_NUM;
      m_valid <= 1'b0;
      u1      <= '0;
      u2      <= '0;
      alpha1  <= '0;
      alpha2  <= '0;
      beta1   <= '0;
      beta2   <= '0;
    end else begin
      if (accept) begin
        term <= sqpd_pkg::TERM_BP_NUM;
      end else if (term_inc) begin
        term <= term + sqpd_pkg::TERM_W'(1);
      end
      if (out_load) begin
        m_valid <= 1'b1;
        u2      <= u1;
        u1      <= u0;
        alpha2  <= alpha1;
        alpha1  <= alpha_cur;
        beta2   <= beta1;
        beta1   <= beta_cur;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      u0    <= $signed(s_axis_tdata[SW-1:0]);
      osc_c <= $signed(s_axis_tdata[2*SW-1:SW]);
      osc_s <= $signed(s_axis_tdata[3*SW-1:2*SW]);
    end
    if ((state == sqpd_pkg::ST_CAPTURE) && (term == sqpd_pkg::TERM_BP_FB2)) begin
      alpha_cur <= round_result;
    end
    if ((state == sqpd_pkg::ST_CAPTURE) && (term == sqpd_pkg::TERM_LP_FB2)) begin
      beta_cur <= round_result;
    end
    if (out_load) begin
      out_q     <= round_result;
      out_alpha <= alpha_cur;
      out_beta  <= beta_cur;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = TDATA_W'({out_beta, out_alpha, out_q});

endmodule

### rtl/sqpd_serial_mac.sv
// ----------------------------------------------------------------------------
// sqpd_serial_mac
// Digit-serial multiply-accumulate: the operand shifts out one digit per
// cycle, most significant first, and the product builds up by Horner steps.
// ----------------------------------------------------------------------------
module sqpd_serial_mac #(
  parameter int MW    = 24,
  parameter int OPW   = 20,
  parameter int ACC_W = 46
) (
  input  logic                    clk,
  input  logic                    rst,
  input  sqpd_pkg::mac_ctrl_t     ctrl,
  input  logic signed [MW-1:0]    mcand_in,
  input  logic signed [OPW-1:0]   opnd_in,
  output logic                    done,
  output logic signed [ACC_W-1:0] acc
);

  localparam int NDIG   = OPW / sqpd_pkg::DIGIT_W;
  localparam int CNT_W  = $clog2(NDIG + 1);
  localparam int PROD_W = MW + sqpd_pkg::DIGIT_W + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NDIG);

  logic signed [MW-1:0]                  mcand;
  logic        [OPW-1:0]                 opnd;
  logic signed [ACC_W-1:0]               part;
  logic        [CNT_W-1:0]               cnt;
  logic                                  busy;
  logic                                  clear;
  logic        [sqpd_pkg::DIGIT_W-1:0]   digit;
  logic signed [sqpd_pkg::DIGIT_W:0]     digit_ext;
  logic signed [PROD_W-1:0]              prod;
  logic signed [ACC_W-1:0]               part_next;

  always_comb begin
    digit = opnd[OPW-1 -: sqpd_pkg::DIGIT_W];
    // Top digit carries the operand sign, the rest are unsigned
    if (cnt == CNT_FULL) begin
      digit_ext = $signed({digit[sqpd_pkg::DIGIT_W-1], digit});
    end else begin
      digit_ext = $signed({1'b0, digit});
    end
    prod      = mcand * digit_ext;
    part_next = (part <<< sqpd_pkg::DIGIT_W) + ACC_W'(prod);
  end

  assign done = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.start) begin
      mcand <= mcand_in;
      opnd  <= opnd_in;
      part  <= '0;
      cnt   <= CNT_FULL;
      clear <= ctrl.clear_acc;
      busy  <= 1'b1;
    end else if (busy) begin
      if (cnt != '0) begin
        part <= part_next;
        opnd <= opnd << sqpd_pkg::DIGIT_W;
        cnt  <= cnt - CNT_W'(1);
      end else begin
        acc  <= (clear ? '0 : acc) + part;
        busy <= 1'b0;
      end
    end
  end

endmodule

### rtl/sqpd_round_sat.sv
// ----------------------------------------------------------------------------
// sqpd_round_sat
// Rounds the accumulated sum half up at one of two fixed binary points and
// saturates it to the sample width; the result is registered.
// ----------------------------------------------------------------------------
module sqpd_round_sat #(
  parameter int ACC_W       = 46,
  parameter int SW          = 16,
  parameter int COEF_FRAC   = 20,
  parameter int SAMPLE_FRAC = 15
) (
  input  logic                      clk,
  input  sqpd_pkg::round_ctrl_t     ctrl,
  input  logic signed [ACC_W-1:0]   acc,
  output logic signed [SW-1:0]      result
);

  localparam logic [ACC_W-1:0] HALF_COEF   = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic [ACC_W-1:0] HALF_SAMPLE = ACC_W'(1) << (SAMPLE_FRAC - 1);
  localparam logic [SW-1:0]    SAT_MAX     = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0]    SAT_MIN     = {1'b1, {(SW-1){1'b0}}};

  logic signed [ACC_W-1:0] rounded;
  logic signed [ACC_W-1:0] shifted;
  logic                    pos_ovf;
  logic                    neg_ovf;
  logic        [SW-1:0]    sat;

  always_comb begin
    rounded = acc + $signed(ctrl.coef_frac ? HALF_COEF : HALF_SAMPLE);
    shifted = ctrl.coef_frac ? (rounded >>> COEF_FRAC) : (rounded >>> SAMPLE_FRAC);
    // Bits above the sign of the result must all match the top bit
    pos_ovf = !shifted[ACC_W-1] && (|shifted[ACC_W-2:SW-1]);
    neg_ovf = shifted[ACC_W-1] && !(&shifted[ACC_W-2:SW-1]);
    if (pos_ovf) begin
      sat = SAT_MAX;
    end else if (neg_ovf) begin
      sat = SAT_MIN;
    end else begin
      sat = shifted[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      result <= $signed(sat);
    end
  end

endmodule

### rtl/sqpd_checker.sv
// ----------------------------------------------------------------------------
// sqpd_checker
// Port-level checks for the phase detector, bound to the top level.
// ----------------------------------------------------------------------------
module sqpd_checker #(
  parameter int  SAMPLE_WIDTH = 16,
  localparam int TDATA_W      = ((3 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // One request in flight: ready drops once a request is taken
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while busy");

  // A new result only appears when the block was busy on a request
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while idle");

  // A stalled result holds
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind sogi_qsg_phase_detector sqpd_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sqpd_checker (.*);

### test/sogi_qsg_phase_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sogi_qsg_phase_detector_tb
// Self-checking bench for the SOGI phase detector. A short table of directed
// requests covers reset state, field extremes and saturation. Random requests
// follow under several coefficient sets. Checked results are compared with a
// bit-exact software model of both biquads and the Park projection, fixed
// rows with their table values. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module sogi_qsg_phase_detector_tb;

  localparam int SAMPLE_W        = 16;
  localparam int COEF_W          = 24;
  localparam int COEF_FRAC       = COEF_W - 4;
  localparam int SAMPLE_FRAC     = SAMPLE_W - 1;
  localparam int TDATA_W         = ((3 * SAMPLE_W + 7) / 8) * 8;
  localparam int SAT_MAX         = 32767;
  localparam int SAT_MIN         = -32768;
  localparam int COEF_MAX        = 8388607;
  localparam int COEF_MIN        = -8388608;
  localparam int UNITY           = 1 << COEF_FRAC;
  localparam int N_PHASES        = 12;
  localparam int ITEMS_PER_PHASE = 136;
  localparam int N_DIRECTED      = 24;
  // Longest legal quiet spell is the receiver hold-off plus one computation;
  // take it several times over.
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int HOLD_OFF_AT     = 400;
  localparam int HOLD_OFF_CYCLES = 1500;

  typedef struct {
    logic [SAMPLE_W-1:0] q_error;
    logic [SAMPLE_W-1:0] alpha_out;
    logic [SAMPLE_W-1:0] beta_out;
  } park_t;

  typedef enum {ROW_COEFS, ROW_CHECKED, ROW_FIXED} row_t;

  typedef enum {SET_TUNED, SET_MAX, SET_MIN, SET_UNITY, SET_RANDOM, SET_MIXED} setting_t;

  // Item rows: val = sample, cos, sin. Coefficient rows: val = b0, a1, a2, qb0.
  typedef struct {
    row_t kind;
    int   val[4];
    int   want[3];
  } stim_row_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [sqpd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [COEF_W-1:0]                cfg_data;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [TDATA_W-1:0]               s_axis_tdata;   // sample, osc_cos, osc_sin
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]               m_axis_tdata;   // q_error, alpha_out, beta_out

  // Model state: coefficients by register index, then the three histories
  int    gains [4];
  int    u_hist [2];
  int    alpha_hist [2];
  int    beta_hist [2];
  park_t expected_park [$];
  int    failures = 0;

  stim_row_t directed [N_DIRECTED] = '{
    // all coefficients zero after reset: everything reads zero
    '{ROW_FIXED,   '{32767, 32767, 32767, 0},      '{0, 0, 0}},
    '{ROW_FIXED,   '{-32768, -32768, -32768, 0},   '{0, 0, 0}},
    '{ROW_FIXED,   '{-1, 1, -1, 0},                '{0, 0, 0}},
    '{ROW_FIXED,   '{0, 0, 0, 0},                  '{0, 0, 0}},
    '{ROW_COEFS,   '{UNITY, 0, 0, UNITY / 4},      '{0, 0, 0}},
    '{ROW_CHECKED, '{32767, 32767, 0, 0},          '{0, 0, 0}},
    '{ROW_CHECKED, '{-32768, -32768, 32767, 0},    '{0, 0, 0}},
    '{ROW_CHECKED, '{32767, 0, -32768, 0},         '{0, 0, 0}},
    '{ROW_CHECKED, '{-32768, 32767, 32767, 0},     '{0, 0, 0}},
    '{ROW_CHECKED, '{0, -32768, -32768, 0},        '{0, 0, 0}},
    '{ROW_COEFS,   '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX}, '{0, 0, 0}},
    '{ROW_CHECKED, '{32767, 32767, 32767, 0},      '{0, 0, 0}},
    '{ROW_CHECKED, '{-32768, -32768, -32768, 0},   '{0, 0, 0}},
    '{ROW_CHECKED, '{1, -1, 1, 0},                 '{0, 0, 0}},
    '{ROW_CHECKED, '{32767, -32768, 32767, 0},     '{0, 0, 0}},
    '{ROW_COEFS,   '{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN}, '{0, 0, 0}},
    '{ROW_CHECKED, '{32767, 32767, 32767, 0},      '{0, 0, 0}},
    '{ROW_CHECKED, '{-32768, -32768, -32768, 0},   '{0, 0, 0}},
    '{ROW_CHECKED, '{12345, -20000, 30000, 0},     '{0, 0, 0}},
    '{ROW_CHECKED, '{-1, -1, -1, 0},               '{0, 0, 0}},
    '{ROW_COEFS,   '{11519, 2073852, -1025541, 90}, '{0, 0, 0}},
    '{ROW_CHECKED, '{20000, 32767, 0, 0},          '{0, 0, 0}},
    '{ROW_CHECKED, '{-15000, 23170, 23170, 0},     '{0, 0, 0}},
    '{ROW_CHECKED, '{-32768, 0, -32768, 0},        '{0, 0, 0}}
  };

  sogi_qsg_phase_detector uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Round half up by frac bits, then clamp to the sample range
  function automatic int round_sat(input longint acc, input int frac);
    longint r;
    r = (acc + (longint'(1) <<< (frac - 1))) >>> frac;
    if (r > SAT_MAX) return SAT_MAX;
    if (r < SAT_MIN) return SAT_MIN;
    return int'(r);
  endfunction

  function automatic park_t sogi_step(input int u0, input int cs, input int sn);
    longint acc;
    int     alpha;
    int     beta;
    int     q;
    park_t  r;
    acc = longint'(gains[sqpd_pkg::CFG_BP_GAIN]) * (u0 - u_hist[1])
        + longint'(gains[sqpd_pkg::CFG_FB_FIRST]) * alpha_hist[0]
        + longint'(gains[sqpd_pkg::CFG_FB_SECOND]) * alpha_hist[1];
    alpha = round_sat(acc, COEF_FRAC);
    acc = longint'(gains[sqpd_pkg::CFG_LP_GAIN]) * (u0 + 2 * u_hist[0] + u_hist[1])
        + longint'(gains[sqpd_pkg::CFG_FB_FIRST]) * beta_hist[0]
        + longint'(gains[sqpd_pkg::CFG_FB_SECOND]) * beta_hist[1];
    beta = round_sat(acc, COEF_FRAC);
    acc = longint'(cs) * alpha + longint'(sn) * beta;
    q = round_sat(acc, SAMPLE_FRAC);
    u_hist[1]     = u_hist[0];
    u_hist[0]     = u0;
    alpha_hist[1] = alpha_hist[0];
    alpha_hist[0] = alpha;
    beta_hist[1]  = beta_hist[0];
    beta_hist[0]  = beta;
    r.q_error   = q[SAMPLE_W-1:0];
    r.alpha_out = alpha[SAMPLE_W-1:0];
    r.beta_out  = beta[SAMPLE_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [SAMPLE_W-1:0] want,
                                      input logic [SAMPLE_W-1:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, $signed(want), $signed(got));
      failures++;
    end
  endfunction

  function automatic int rand_word();
    case ($urandom_range(0, 19))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2:       return 0;
      3:       return -1;
      4, 5, 6: return int'($urandom_range(0, 511)) - 256;
      default: return int'($urandom & 32'h0000_FFFF) - 32768;
    endcase
  endfunction

  function automatic int rand_coef();
    case ($urandom_range(0, 4))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return 0;
      3:       return UNITY;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 6);
    if (r < 97) return $urandom_range(7, 70);
    return $urandom_range(100, 300);
  endfunction

  function automatic int sink_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 30);
    return $urandom_range(60, 200);
  endfunction

  task automatic pick_setting(input setting_t k, output int b0, output int a1,
                              output int a2, output int qb0);
    case (k)
      SET_TUNED: begin
        b0  = 11519 + int'($urandom_range(0, 63)) - 32;
        a1  = 2073852 + int'($urandom_range(0, 63)) - 32;
        a2  = -1025541 + int'($urandom_range(0, 63)) - 32;
        qb0 = 90 + int'($urandom_range(0, 15)) - 8;
      end
      SET_MAX: begin
        b0 = COEF_MAX; a1 = COEF_MAX; a2 = COEF_MAX; qb0 = COEF_MAX;
      end
      SET_MIN: begin
        b0 = COEF_MIN; a1 = COEF_MIN; a2 = COEF_MIN; qb0 = COEF_MIN;
      end
      SET_UNITY: begin
        b0 = UNITY; a1 = 0; a2 = 0; qb0 = UNITY / 4;
      end
      SET_RANDOM: begin
        b0 = int'($urandom); a1 = int'($urandom); a2 = int'($urandom); qb0 = int'($urandom);
      end
      default: begin
        b0 = rand_coef(); a1 = rand_coef(); a2 = rand_coef(); qb0 = rand_coef();
      end
    endcase
  endtask

  task automatic write_reg(input logic [sqpd_pkg::CFG_INDEX_W-1:0] idx, input int v);
    logic signed [COEF_W-1:0] c;
    c = v[COEF_W-1:0];
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[COEF_W-1:0];
    @(posedge clk);
    gains[idx] = c;
  endtask

  task automatic write_coefs(input int b0, input int a1, input int a2, input int qb0);
    write_reg(sqpd_pkg::CFG_BP_GAIN, b0);
    write_reg(sqpd_pkg::CFG_FB_FIRST, a1);
    write_reg(sqpd_pkg::CFG_FB_SECOND, a2);
    write_reg(sqpd_pkg::CFG_LP_GAIN, qb0);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every outstanding result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_park.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic offer_sample(input int smp, input int cs, input int sn,
                              input bit fixed, input park_t want);
    park_t pred;
    s_axis_tdata  <= {sn[SAMPLE_W-1:0], cs[SAMPLE_W-1:0], smp[SAMPLE_W-1:0]};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pred = sogi_step(smp, cs, sn);
    if (fixed) begin
      expected_park.push_back(want);
    end else begin
      expected_park.push_back(pred);
    end
  endtask

  initial begin : stimulus
    int       b0, a1, a2, qb0;
    park_t    want;
    setting_t k;
    bit       no_gaps;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = sqpd_pkg::CFG_BP_GAIN;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    gains         = '{0, 0, 0, 0};
    u_hist        = '{0, 0};
    alpha_hist    = '{0, 0};
    beta_hist     = '{0, 0};
    want          = '{default: '0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      case (directed[i].kind)
        ROW_COEFS: begin
          drain();
          write_coefs(directed[i].val[0], directed[i].val[1], directed[i].val[2],
                      directed[i].val[3]);
        end
        ROW_FIXED: begin
          want.q_error   = directed[i].want[0][SAMPLE_W-1:0];
          want.alpha_out = directed[i].want[1][SAMPLE_W-1:0];
          want.beta_out  = directed[i].want[2][SAMPLE_W-1:0];
          offer_sample(directed[i].val[0], directed[i].val[1], directed[i].val[2], 1'b1, want);
        end
        default: begin
          offer_sample(directed[i].val[0], directed[i].val[1], directed[i].val[2], 1'b0, want);
        end
      endcase
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0:       k = SET_TUNED;
        1:       k = SET_MAX;
        2:       k = SET_MIN;
        default: k = setting_t'($urandom_range(0, 5));
      endcase
      pick_setting(k, b0, a1, a2, qb0);
      write_coefs(b0, a1, a2, qb0);
      no_gaps = (p % 4 == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // pause mid-phase until the pipeline is empty
        if (p == 6 && n == ITEMS_PER_PHASE / 2) drain();
        if (!no_gaps) hold_off(sender_gap());
        offer_sample(rand_word(), rand_word(), rand_word(), 1'b0, want);
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (failures == 0 && expected_park.size() == 0) begin
      $display("[sogi_qsg_phase_detector] OK");
    end else begin
      $display("[sogi_qsg_phase_detector] ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int    gap_left;
    int    mode_left;
    int    results_seen;
    bit    quiet;
    park_t want;
    gap_left     = 0;
    mode_left    = 0;
    results_seen = 0;
    quiet        = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_park.size() == 0) begin
          $display("%0t unexpected result: expected none, got %h", $time, m_axis_tdata);
          failures++;
        end else begin
          want = expected_park.pop_front();
          check_field("q_error", want.q_error, m_axis_tdata[SAMPLE_W-1:0]);
          check_field("alpha_out", want.alpha_out, m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);
          check_field("beta_out", want.beta_out, m_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W]);
        end
        results_seen++;
        // hold off long enough for the block to back up into its input
        if (results_seen == HOLD_OFF_AT) gap_left = HOLD_OFF_CYCLES;
      end
      if (mode_left == 0) begin
        quiet     = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(200, 800);
      end else begin
        mode_left--;
      end
      if (gap_left == 0 && !quiet && $urandom_range(0, 15) == 0) gap_left = sink_stall();
      if (gap_left > 0) begin
        m_axis_tready <= 1'b0;
        gap_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
        $display("[sogi_qsg_phase_detector] ERROR");
        $finish;
      end
    end
  end

endmodule
